### design/pfsa_pkg.sv
// Shared constants, codes and types of the page free-stack allocator.
`timescale 1ns / 1ps

package pfsa_pkg;

    // Pool and field geometry
    localparam int MAX_PAGES = 1024;
    localparam int IDX_W     = $clog2(MAX_PAGES);
    localparam int DEPTH_W   = IDX_W + 1;
    localparam int NUMP_W    = 11;
    localparam int COUNT_W   = 11;
    localparam int OFF_W     = 26;
    localparam int PB_W      = 17;
    localparam int STAT_W    = 3;

    // Shared shift-add / shift-subtract unit geometry
    localparam int ACC_W  = (IDX_W + PB_W > OFF_W) ? (IDX_W + PB_W) : (OFF_W + 1);
    localparam int ADD_W  = ACC_W + 1;
    localparam int STEP_W = $clog2(OFF_W);

    // Register indexes
    localparam logic CFG_NUM_PAGES  = 1'b0;
    localparam logic CFG_PAGE_BYTES = 1'b1;

    // Request kinds
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_PAGE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE      = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISALIGNED = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW   = 3'd4;

    typedef struct packed {
        logic start;
        logic is_mul;
    } arith_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] res;
        logic [PB_W-1:0]  rem;
    } arith_rsp_t;

endpackage

### design/pfsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/pfsa_arith.sv
// Shared iterative unit: shift-add multiply and restoring divide on one adder.
`timescale 1ns / 1ps

module pfsa_arith import pfsa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  arith_req_t       req_i,
    input  logic [OFF_W-1:0] opa_i,
    input  logic [PB_W-1:0]  opb_i,
    output arith_rsp_t       rsp_o
);

    logic              busy_reg, busy_next;
    logic              mul_reg, mul_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [PB_W-1:0]   rem_reg, rem_next;
    logic [PB_W-1:0]   opb_reg, opb_next;
    logic [IDX_W-1:0]  mpl_reg, mpl_next;

    logic [PB_W:0]     trial;
    logic [ADD_W-1:0]  add_a, add_b, sum;
    logic              add_c;
    logic              borrow;

    // Shared adder: trial subtract when dividing, shifted accumulate when multiplying
    always_comb begin
        trial = {rem_reg, acc_reg[OFF_W-1]};
        if (mul_reg) begin
            add_a = {acc_reg, 1'b0};
            add_b = mpl_reg[IDX_W-1] ? ADD_W'(opb_reg) : '0;
            add_c = 1'b0;
        end else begin
            add_a = ADD_W'(trial);
            add_b = ~ADD_W'(opb_reg);
            add_c = 1'b1;
        end
        sum    = add_a + add_b + ADD_W'(add_c);
        borrow = sum[ADD_W-1];
    end

    // Load operands on start, then advance one bit per cycle
    always_comb begin
        busy_next = busy_reg;
        mul_next  = mul_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        opb_next  = opb_reg;
        mpl_next  = mpl_reg;
        if (busy_reg) begin
            if (mul_reg) begin
                acc_next = sum[ACC_W-1:0];
                mpl_next = {mpl_reg[IDX_W-2:0], 1'b0};
            end else begin
                acc_next = {acc_reg[ACC_W-2:0], ~borrow};
                rem_next = borrow ? trial[PB_W-1:0] : sum[PB_W-1:0];
            end
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req_i.start) begin
            busy_next = 1'b1;
            mul_next  = req_i.is_mul;
            cnt_next  = req_i.is_mul ? STEP_W'(IDX_W - 1) : STEP_W'(OFF_W - 1);
            acc_next  = req_i.is_mul ? '0 : ACC_W'(opa_i);
            rem_next  = '0;
            opb_next  = opb_i;
            mpl_next  = opa_i[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mul_reg <= mul_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        opb_reg <= opb_next;
        mpl_reg <= mpl_next;
    end

    assign rsp_o.done = done_reg;
    assign rsp_o.res  = acc_reg;
    assign rsp_o.rem  = rem_reg;

endmodule

### design/page_free_stack_allocator.sv
// Page allocator top level: request sequencer, free stack and result register.
// Allocate: RAM read, then a 10-step shift-add multiply in the shared unit, then the output step;
//   no new word is taken until the result is out; no free page: straight to the output step.
// Release: 26-step restoring divide, then the output step; no new word is taken until then.
// One request at a time; an unread result holds the next one in its output step.
// Reset (aresetn low, synchronous): 1024 pages of 4096 bytes, stack holds page 0.
`timescale 1ns / 1ps

module page_free_stack_allocator import pfsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [25:0] release_offset, [31:26] zero
    input  logic        s_tuser,   // [0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [2:0] status, [28:3] page_offset, [39:29] pages_free
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [NUMP_W-1:0]  num_pages_reg, num_pages_next;
    logic [PB_W-1:0]    page_bytes_reg, page_bytes_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               bz_reg, bz_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [OFF_W-1:0]   res_off_reg, res_off_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [39:0]        m_tdata_reg, m_tdata_next;

    logic [PB_W-1:0]    pb_eff;
    logic [NUMP_W-1:0]  pool, pool_cfg;
    logic [DEPTH_W-1:0] depth_dec;
    logic [IDX_W-1:0]   page;
    logic [NUMP_W-1:0]  page_inc;
    logic               accept;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_wdata, ram_rdata;

    arith_req_t         arith_req;
    arith_rsp_t         arith_rsp;
    logic [OFF_W-1:0]   arith_opa;

    pfsa_ram #(
        .WIDTH(IDX_W),
        .DEPTH(MAX_PAGES)
    ) u_stack (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(depth_dec[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    pfsa_arith u_arith (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req_i  (arith_req),
        .opa_i  (arith_opa),
        .opb_i  (pb_eff),
        .rsp_o  (arith_rsp)
    );

    // Effective page size and pool size
    always_comb begin
        if (page_bytes_reg == '0) begin
            pb_eff = PB_W'(1);
        end else if (page_bytes_reg[PB_W-1]) begin
            pb_eff = {1'b1, {(PB_W-1){1'b0}}};
        end else begin
            pb_eff = page_bytes_reg;
        end
        pool     = (32'(num_pages_reg) > MAX_PAGES) ? NUMP_W'(MAX_PAGES) : num_pages_reg;
        pool_cfg = (32'(cfg_data[NUMP_W-1:0]) > MAX_PAGES) ? NUMP_W'(MAX_PAGES)
                                                           : cfg_data[NUMP_W-1:0];
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign depth_dec = depth_reg - DEPTH_W'(1);
    // Entry zero reads as page zero until first written after reinit
    assign page      = (bz_reg && depth_dec == '0) ? '0 : ram_rdata;
    assign page_inc  = NUMP_W'(page) + NUMP_W'(1);
    assign arith_opa = (state_reg == S_READ) ? OFF_W'(page) : s_tdata[OFF_W-1:0];

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        num_pages_next  = num_pages_reg;
        page_bytes_next = page_bytes_reg;
        depth_next      = depth_reg;
        count_next      = count_reg;
        bz_next         = bz_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        arith_req.start  = 1'b0;
        arith_req.is_mul = (state_reg == S_READ);

        // Drop a delivered word
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Register writes; pool size reinitializes the stack
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_NUM_PAGES: begin
                    num_pages_next = cfg_data[NUMP_W-1:0];
                    depth_next     = DEPTH_W'(1);
                    count_next     = pool_cfg;
                    bz_next        = 1'b1;
                end
                CFG_PAGE_BYTES: begin
                    page_bytes_next = cfg_data;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_off_next = '0;
                    if (s_tuser == OP_RELEASE) begin
                        arith_req.start = 1'b1;
                        state_next      = S_DIV;
                    end else if (depth_reg == '0 || count_reg == '0) begin
                        res_status_next = ST_NO_PAGE;
                        state_next      = S_OUT;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                // Pop, lazily push the following page, start the offset multiply
                arith_req.start = 1'b1;
                count_next      = count_reg - COUNT_W'(1);
                if (depth_dec == '0 && page_inc < pool) begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = page_inc[IDX_W-1:0];
                    bz_next    = 1'b0;
                    depth_next = DEPTH_W'(1);
                end else begin
                    depth_next = depth_dec;
                end
                state_next = S_MUL;
            end
            S_MUL: begin
                if (arith_rsp.done) begin
                    res_status_next = ST_OK;
                    res_off_next    = arith_rsp.res[OFF_W-1:0];
                    state_next      = S_OUT;
                end
            end
            S_DIV: begin
                if (arith_rsp.done) begin
                    if (arith_rsp.res[OFF_W-1:0] >= OFF_W'(pool)) begin
                        res_status_next = ST_RANGE;
                    end else if (arith_rsp.rem != '0) begin
                        res_status_next = ST_MISALIGNED;
                    end else if (depth_reg >= DEPTH_W'(MAX_PAGES)) begin
                        res_status_next = ST_OVERFLOW;
                    end else begin
                        res_status_next = ST_OK;
                        ram_we          = 1'b1;
                        ram_waddr       = depth_reg[IDX_W-1:0];
                        ram_wdata       = arith_rsp.res[IDX_W-1:0];
                        depth_next      = depth_reg + DEPTH_W'(1);
                        if (depth_reg == '0) begin
                            bz_next = 1'b0;
                        end
                        if (count_reg != '1) begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the result register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {count_reg, res_off_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            num_pages_reg  <= NUMP_W'(1024);
            page_bytes_reg <= PB_W'(4096);
            depth_reg      <= DEPTH_W'(1);
            count_reg      <= NUMP_W'(MAX_PAGES > 1024 ? 1024 : MAX_PAGES);
            bz_reg         <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            num_pages_reg  <= num_pages_next;
            page_bytes_reg <= page_bytes_next;
            depth_reg      <= depth_next;
            count_reg      <= count_next;
            bz_reg         <= bz_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Stack writes happen only when popping or after a release check
    a_ram_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_READ || state_reg == S_DIV))
        else $error("stack written outside pop or release");

    // Stack depth never passes its capacity
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(MAX_PAGES))
        else $error("stack depth above capacity");

    // Shared unit finishes only while the sequencer waits on it
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        arith_rsp.done |-> (state_reg == S_MUL || state_reg == S_DIV))
        else $error("unexpected completion from shared unit");

    // An accepted word blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input ready right after accepting a word");

endmodule
